[rtl/tfir_pkg.sv]
// shared types, constants and saturation helpers for the transposed fir filter
`timescale 1ns / 1ps

package tfir_pkg;

   localparam int TAP_COUNT      = 4;
   localparam int DELAY_COUNT    = TAP_COUNT - 1;
   localparam int COEFF_WIDTH    = 32;
   localparam int SAMPLE_WIDTH   = 16;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic signed [33:0] SUM_MAX   = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] SUM_MIN   = 34'sh3_8000_0000;
   localparam logic signed [31:0] Q31_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q31_MIN   = 32'sh8000_0000;
   localparam logic signed [33:0] ROUND_BIT = 34'sh0_0000_8000;

   typedef enum logic [1:0] {
      REG_COEFF_TAP0 = 2'd0,
      REG_COEFF_TAP1 = 2'd1,
      REG_COEFF_TAP2 = 2'd2,
      REG_COEFF_TAP3 = 2'd3
   } reg_index_type;

   typedef logic [COEFF_WIDTH-1:0] coeff_type;
   typedef coeff_type [TAP_COUNT-1:0] coeff_array_type;

   typedef struct packed {
      logic signed [31:0] product;
      logic               sat;
   } tap_result_type;

   function automatic logic signed [33:0] sext34(input logic signed [31:0] v);
      return $signed({{2{v[31]}}, v});
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > SUM_MAX) begin
         r = Q31_MAX;
      end else if (v < SUM_MIN) begin
         r = Q31_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic ovf32(input logic signed [33:0] v);
      return (v > SUM_MAX) || (v < SUM_MIN);
   endfunction

endpackage

[rtl/transposed_fir_q31_coeff.sv]
// top level of the four-tap transposed fir filter with q31 coefficients
// usage:
//   req_* is the sample stream in (tdata = sample_in, tlast = sample_last).
//   rsp_* is the filtered stream out (tdata = sample_out, tuser = saturated,
//   tlast = out_last). csr_* writes and reads the four coefficients, taps 0
//   to 3 at byte addresses 0, 4, 8 and 12; write them only while idle.
// timing:
//   a beat taken on req is held in an input register; when it advances, the
//   four tap products, the delay line update and the rounding all settle
//   into the output register, from which the result shows on rsp. one beat
//   per cycle is sustained while rsp_tready stays high, set by the single
//   pass through the tap multipliers and the saturating adders.
// reset:
//   clears both pipeline stages, the three delay registers and the
//   coefficients.
// backpressure:
//   while rsp_tready is low the result holds; the input register still takes
//   one more beat, then req_tready drops until the output drains.
//   the delay line moves only when a beat passes into the output register.
`timescale 1ns / 1ps

module transposed_fir_q31_coeff
   import tfir_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [15:0]               req_tdata,   // [15:0] sample_in
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata,   // [15:0] sample_out
   output logic                      rsp_tuser,   // [0] saturated
   output logic                      rsp_tlast,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   coeff_array_type                coeff;
   tap_result_type [TAP_COUNT-1:0] tap;

   logic                           in_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff;
   logic                           in_last_ff;

   logic                           out_valid_ff;
   logic [15:0]                    out_sample_ff;
   logic                           out_sat_ff;
   logic                           out_last_ff;

   logic signed [31:0]             partial_ff [DELAY_COUNT];
   logic signed [31:0]             partial_in [DELAY_COUNT];

   logic                           advance;
   logic                           req_fire;
   logic signed [33:0]             out_sum_wide;
   logic signed [31:0]             out_sum;
   logic signed [33:0]             round_wide;
   logic signed [31:0]             rounded;
   logic signed [33:0]             top_wide;
   logic signed [33:0]             mid_wide;
   logic                           step_sat;

   tfir_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coeff       (coeff)
   );

   for (genvar g = 0; g < TAP_COUNT; g++) begin : g_tap
      tfir_tap u_tap (
         .coeff  (coeff[g]),
         .sample (in_sample_ff),
         .result (tap[g])
      );
   end

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // output sum and rounding
   assign out_sum_wide = sext34(tap[0].product) + sext34(partial_ff[2]);
   assign out_sum      = sat32(out_sum_wide);
   assign round_wide   = sext34(out_sum) + ROUND_BIT;
   assign rounded      = sat32(round_wide);

   // delay line shifts toward the output
   assign top_wide = sext34(tap[1].product) + sext34(partial_ff[1]);
   assign mid_wide = sext34(tap[2].product) + sext34(partial_ff[0]);

   always_comb begin
      partial_in[2] = sat32(top_wide);
      partial_in[1] = sat32(mid_wide);
      partial_in[0] = tap[3].product;
   end

   assign step_sat = tap[0].sat || tap[1].sat || tap[2].sat || tap[3].sat
                  || ovf32(out_sum_wide) || ovf32(round_wide)
                  || ovf32(top_wide) || ovf32(mid_wide);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < DELAY_COUNT; i++) begin
            partial_ff[i] <= '0;
         end
      end else begin
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            for (int i = 0; i < DELAY_COUNT; i++) begin
               partial_ff[i] <= partial_in[i];
            end
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_sample_ff <= $signed(req_tdata);
         in_last_ff   <= req_tlast;
      end
      if (advance) begin
         out_sample_ff <= rounded[31:16];
         out_sat_ff    <= step_sat;
         out_last_ff   <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sample_ff;
   assign rsp_tuser  = out_sat_ff;
   assign rsp_tlast  = out_last_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_sample_ff))
      else $error("stalled input register lost its beat");

   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("advanced beat did not reach the output register");

   a_delay_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(partial_ff[0]) && $stable(partial_ff[2]))
      else $error("delay line moved without a beat");

endmodule

[rtl/tfir_csr.sv]
// coefficient register file behind the apb-style configuration port
`timescale 1ns / 1ps

module tfir_csr
   import tfir_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output coeff_array_type           coeff
);

   coeff_array_type coeff_ff;
   coeff_array_type coeff_in;
   reg_index_type   index;
   logic            wr_en;

   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign coeff      = coeff_ff;

   always_comb begin
      coeff_in = coeff_ff;
      if (wr_en) begin
         unique case (index)
            REG_COEFF_TAP0: coeff_in[0] = csr_pwdata;
            REG_COEFF_TAP1: coeff_in[1] = csr_pwdata;
            REG_COEFF_TAP2: coeff_in[2] = csr_pwdata;
            REG_COEFF_TAP3: coeff_in[3] = csr_pwdata;
            default:        coeff_in    = coeff_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_COEFF_TAP0: csr_prdata = coeff_ff[0];
         REG_COEFF_TAP1: csr_prdata = coeff_ff[1];
         REG_COEFF_TAP2: csr_prdata = coeff_ff[2];
         REG_COEFF_TAP3: csr_prdata = coeff_ff[3];
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

endmodule

[rtl/tfir_tap.sv]
// one tap product: split q31 coefficient times 16-bit sample, saturated to 32 bits
`timescale 1ns / 1ps

module tfir_tap
   import tfir_pkg::*;
(
   input  coeff_type                       coeff,
   input  logic signed [SAMPLE_WIDTH-1:0]  sample,
   output tap_result_type                  result
);

   logic signed [15:0] hi;
   logic signed [15:0] lo;
   logic signed [31:0] prod_hi;
   logic signed [31:0] prod_lo;
   logic               extreme;
   logic signed [33:0] acc;
   logic signed [33:0] lo_term;
   logic signed [33:0] total;

   assign hi      = $signed(coeff[31:16]);
   assign lo      = $signed({1'b0, coeff[15:1]});
   assign prod_hi = hi * sample;
   assign prod_lo = lo * sample;
   assign extreme = (hi == 16'sh8000) && (sample == 16'sh8000);

   // doubled high product, pinned to max when both operands are most negative
   assign acc     = extreme ? SUM_MAX : $signed({prod_hi[31], prod_hi, 1'b0});
   // floor of the low product over 2^15, doubled
   assign lo_term = $signed({{16{prod_lo[31]}}, prod_lo[31:15], 1'b0});
   assign total   = acc + lo_term;

   assign result.product = sat32(total);
   assign result.sat     = extreme || ovf32(total);

endmodule

[tb/sv/transposed_fir_q31_coeff_tb.sv]
// self-checking stream testbench for the four-tap transposed fir filter with q31 coefficients
`timescale 1ns / 1ps

module transposed_fir_q31_coeff_tb;
   import tfir_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_COUNT  = 9;
   localparam int PHASE_ITEMS  = 200;
   localparam int REPORT_LIMIT = 10;

   typedef enum logic {ROW_SAMPLE, ROW_COEFF} row_kind_type;
   typedef enum logic {RX_FREE, RX_CHOPPY} rx_mode_type;

   typedef struct {
      row_kind_type  kind;
      reg_index_type idx;
      logic [31:0]   value;
      logic [15:0]   sample;
      logic          last;
      logic          typed;
      logic [15:0]   want_data;
      logic          want_sat;
   } stim_row_type;

   typedef struct {
      logic [15:0] data;
      logic        sat;
      logic        last;
   } filt_beat_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [15:0]               req_tdata;   // [15:0] sample_in
   logic                      req_tlast;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [15:0]               rsp_tdata;   // [15:0] sample_out
   logic                      rsp_tuser;   // [0] saturated
   logic                      rsp_tlast;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   logic [31:0]   coeff_q31 [TAP_COUNT];
   longint        psum_model [DELAY_COUNT];
   filt_beat_type pending_out [$];
   stim_row_type  directed_rows [$];
   int            mismatches = 0;
   int            cycles = 0;
   rx_mode_type   rx_mode = RX_FREE;
   logic          hold_request = 1'b0;

   transposed_fir_q31_coeff i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // saturating q31 helpers
   function automatic longint clip_q31(input longint v, inout bit hit);
      longint r;
      r = v;
      if (v > longint'(Q31_MAX)) begin
         hit = 1'b1;
         r = longint'(Q31_MAX);
      end else if (v < longint'(Q31_MIN)) begin
         hit = 1'b1;
         r = longint'(Q31_MIN);
      end
      return r;
   endfunction

   function automatic longint tap_mult(input logic [31:0] c, input logic signed [15:0] x,
                                       inout bit hit);
      longint hi;
      longint lo;
      longint xs;
      longint acc;
      hi = longint'($signed(c[31:16]));
      lo = longint'(c[15:1]);
      xs = longint'(x);
      if (hi == -32768 && xs == -32768) begin
         hit = 1'b1;
         acc = longint'(Q31_MAX);
      end else begin
         acc = 2 * hi * xs;
      end
      return clip_q31(acc + 2 * ((lo * xs) >>> 15), hit);
   endfunction

   function automatic filt_beat_type filter_step(input logic [15:0] s, input logic l);
      filt_beat_type y;
      bit            hit;
      longint        p [TAP_COUNT];
      longint        acc;
      longint        rnd;
      hit = 1'b0;
      for (int t = 0; t < TAP_COUNT; t++) begin
         p[t] = tap_mult(coeff_q31[t], s, hit);
      end
      acc = clip_q31(p[0] + psum_model[2], hit);
      rnd = clip_q31(acc + 32768, hit);
      psum_model[2] = clip_q31(p[1] + psum_model[1], hit);
      psum_model[1] = clip_q31(p[2] + psum_model[0], hit);
      psum_model[0] = p[3];
      y.data = rnd[31:16];
      y.sat  = hit;
      y.last = l;
      return y;
   endfunction

   // result beat check
   always @(posedge clock) begin
      filt_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_out.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("unexpected beat: data %h sat %b last %b", rsp_tdata, rsp_tuser,
                        rsp_tlast);
            end
         end else begin
            want = pending_out.pop_front();
            if (rsp_tdata !== want.data || rsp_tuser !== want.sat
                || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("mismatch: data exp %h got %h, sat exp %b got %b, last exp %b got %b",
                           want.data, rsp_tdata, want.sat, rsp_tuser, want.last, rsp_tlast);
               end
            end
         end
      end
   end

   // result side stalls
   always @(negedge clock) begin
      int         hold_left;
      logic [5:0] pat_pos;
      logic [7:0] stall_pattern;
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (pat_pos == 6'd0 || pat_pos === 6'bx) begin
            pat_pos = 6'd0;
            stall_pattern = (rx_mode == RX_FREE) ? 8'h00 : 8'($urandom());
         end
         rsp_tready <= ~stall_pattern[pat_pos[2:0]];
         pat_pos = pat_pos + 6'd1;
      end
   end

   task automatic idle_req(input int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      while (pending_out.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_coeff(input reg_index_type idx, input logic [31:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      coeff_q31[idx] = v;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic feed_sample(input logic [15:0] s, input logic l, input logic typed,
                              input logic [15:0] ty, input logic tsat);
      filt_beat_type y;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      y = filter_step(s, l);
      if (typed) begin
         y.data = ty;
         y.sat  = tsat;
      end
      pending_out.push_back(y);
   endtask

   function automatic void add_row(input row_kind_type kind, input reg_index_type idx,
                                   input logic [31:0] value, input logic [15:0] s,
                                   input logic l, input logic typed,
                                   input logic [15:0] ty, input logic tsat);
      stim_row_type r;
      r.kind = kind;
      r.idx = idx;
      r.value = value;
      r.sample = s;
      r.last = l;
      r.typed = typed;
      r.want_data = ty;
      r.want_sat = tsat;
      directed_rows.push_back(r);
   endfunction

   function automatic logic [31:0] pick_coeff();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: v = 32'h8000_0000;
         1: v = 32'h7FFF_FFFF;
         2: v = 32'h0000_0000;
         3: v = 32'($urandom_range(0, 32'h001F_FFFF));
         4: v = -32'($urandom_range(0, 32'h001F_FFFF));
         default: v = $urandom();
      endcase
      return v;
   endfunction

   function automatic logic [15:0] pick_sample();
      logic [15:0] s;
      case ($urandom_range(0, 9))
         0: s = 16'h8000;
         1: s = 16'h7FFF;
         2: s = 16'h0000;
         3: s = 16'hFFFF;
         4: s = 16'($urandom_range(0, 511)) - 16'd256;
         default: s = 16'($urandom());
      endcase
      return s;
   endfunction

   initial begin
      stim_row_type row;
      logic [31:0]  v;
      int           sent;
      int           burst;
      bit           gappy;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      for (int t = 0; t < TAP_COUNT; t++) coeff_q31[t] = '0;
      for (int d = 0; d < DELAY_COUNT; d++) psum_model[d] = 0;

      // zero coefficients give zero out, extreme product saturates, block end keeps state
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h7FFF, 1'b0, 1'b1, 16'h0000, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h8000, 1'b1, 1'b1, 16'h0000, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h0001, 1'b0, 1'b1, 16'h0000, 1'b0);
      add_row(ROW_COEFF, REG_COEFF_TAP0, 32'h8000_0000, 0, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h8000, 1'b0, 1'b1, 16'h7FFF, 1'b1);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h7FFF, 1'b1, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'hFFFF, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_COEFF, REG_COEFF_TAP0, 32'h7FFF_FFFF, 0, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_COEFF, REG_COEFF_TAP1, 32'h7FFF_FFFF, 0, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_COEFF, REG_COEFF_TAP2, 32'h8000_0000, 0, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_COEFF, REG_COEFF_TAP3, 32'h8000_0000, 0, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h7FFF, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h7FFF, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h8000, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h8000, 1'b1, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h7FFF, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h0000, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'hFFFF, 1'b1, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h8000, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_COEFF, REG_COEFF_TAP0, 32'h4000_0000, 0, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_COEFF, REG_COEFF_TAP1, 32'h0000_FFFF, 0, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_COEFF, REG_COEFF_TAP2, 32'hFFFF_0001, 0, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_COEFF, REG_COEFF_TAP3, 32'hC000_0000, 0, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h4000, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'hC000, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h5555, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'hAAAA, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h1234, 1'b1, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h0001, 1'b0, 1'b0, 0, 1'b0);
      add_row(ROW_SAMPLE, REG_COEFF_TAP0, 0, 16'h0000, 1'b0, 1'b0, 0, 1'b0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      rx_mode = RX_CHOPPY;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_COEFF) begin
            idle_req(1);
            wait_drained();
            write_coeff(row.idx, row.value);
         end else begin
            feed_sample(row.sample, row.last, row.typed, row.want_data, row.want_sat);
         end
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         idle_req(1);
         wait_drained();
         for (int t = 0; t < TAP_COUNT; t++) begin
            if (ph == 0) v = 32'h7FFF_FFFF;
            else if (ph == 1) v = 32'h8000_0000;
            else v = pick_coeff();
            write_coeff(reg_index_type'(t), v);
         end
         rx_mode = (ph % 3 == 0) ? RX_FREE : RX_CHOPPY;
         gappy = (ph % 2 == 1);
         if (ph == 2 || ph == 6) begin
            @(posedge clock);
            hold_request = 1'b1;
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
               feed_sample(pick_sample(), $urandom_range(0, 7) == 0, 1'b0, 0, 1'b0);
               sent++;
            end
            if (gappy) idle_req($urandom_range(1, 8));
            if ($urandom_range(0, 11) == 0) begin
               idle_req(1);
               wait_drained();
            end
         end
      end

      idle_req(1);
      rx_mode = RX_FREE;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_out.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
